### src/tlws_pkg.sv
// Package: shared types, constants and helper functions for the lockout block.
`default_nettype none
package tlws_pkg;
	localparam int RecordBytesDefault = 128;
	localparam int SignatureWordsDefault = 8;
	localparam logic [31:0] FnvBasis = 32'h811c9dc5;
	localparam logic [31:0] FnvPrime = 32'h01000193;
	localparam int HeadBytes = 36;

	localparam logic [63:0] DriftReset = 64'h4000000000000000;
	localparam logic [63:0] EntropyReset = 64'd4591870180066957722;
	localparam logic [63:0] InflationReset = 64'd4581421828931458171;
	localparam logic [63:0] ConsensusReset = 64'd4584304132692975288;
	localparam logic [31:0] AgeReset = 32'd90;

	localparam int AddrWidth = 6;
	localparam logic [AddrWidth-1:0] AddrDrift = 6'd0;
	localparam logic [AddrWidth-1:0] AddrEntropy = 6'd8;
	localparam logic [AddrWidth-1:0] AddrInflation = 6'd16;
	localparam logic [AddrWidth-1:0] AddrConsensus = 6'd24;
	localparam logic [AddrWidth-1:0] AddrAge = 6'd32;

	typedef enum logic [1:0] {
		FUNC_CHECK = 2'd0,
		FUNC_SHADOW = 2'd1,
		FUNC_UNLOCK = 2'd2,
		FUNC_INIT = 2'd3
	} func_t;

	localparam logic [2:0] KindDrift = 3'd1;
	localparam logic [2:0] KindEntropy = 3'd2;
	localparam logic [2:0] KindInflation = 3'd3;
	localparam logic [2:0] KindConsensus = 3'd4;
	localparam logic [2:0] KindAge = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SINGLE,
		ST_FNV,
		ST_MIX,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] trigger_kind;
		logic [63:0] measured_value;
		logic [31:0] day_count;
		logic [1:0] start_mode;
		logic [63:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic contained;
		logic [1:0] mode;
		logic locked;
		logic [63:0] incident_num;
		logic [2:0] word_index;
		logic [31:0] signature_word;
		logic last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item, apply mode functions
		logic trip;      // commit trip: id, mode, lock
		logic fnv_start;
		logic fnv_step;
		logic mix_step;
		logic out_single;
		logic out_word;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_check;
		logic trips;
		logic fnv_done;
		logic word_last;
	} sts_t;

	// exact int32 -> double
	function automatic logic [63:0] int_to_double(input logic [31:0] v);
		logic [31:0] mag;
		logic [63:0] res;
		logic [4:0] msb;
		logic [51:0] frac;
		logic [83:0] sh;
		res = 64'd0;
		msb = 5'd0;
		mag = v[31] ? (~v + 32'd1) : v;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) begin
				msb = 5'(i);
			end
		end
		sh = {52'd0, mag} << (6'd52 - {1'b0, msb});
		frac = sh[51:0];
		if (mag != 32'd0) begin
			res = {v[31], 11'(11'd1023 + {6'd0, msb}), frac};
		end
		return res;
	endfunction

	// IEEE a <= b, false on NaN
	function automatic logic double_le(input logic [63:0] a, input logic [63:0] b);
		logic a_nan;
		logic b_nan;
		logic le;
		a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
		b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
		if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
			le = 1'b1;
		end else if (a[63] != b[63]) begin
			le = a[63];
		end else if (!a[63]) begin
			le = a[62:0] <= b[62:0];
		end else begin
			le = a[62:0] >= b[62:0];
		end
		return le && !a_nan && !b_nan;
	endfunction
endpackage
`default_nettype wire

### src/tlws_stream_if.sv
// Interface: valid/ready channel carrying one payload item.
`default_nettype none
interface tlws_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### src/tlws_ctrl.sv
// Controller: sequences load, compare, FNV chain, mixing and result delivery.
`default_nettype none
module tlws_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire tlws_pkg::sts_t sts,
	output tlws_pkg::cmd_t cmd
);
	tlws_pkg::state_t state_q, state_next;
	logic out_take;

	assign out_take = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlws_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tlws_pkg::ST_IDLE: begin
				if (in_valid) state_next = tlws_pkg::ST_DECIDE;
			end
			tlws_pkg::ST_DECIDE: begin
				if (sts.is_check && sts.trips) state_next = tlws_pkg::ST_FNV;
				else state_next = tlws_pkg::ST_SINGLE;
			end
			tlws_pkg::ST_SINGLE: begin
				if (out_take) state_next = tlws_pkg::ST_IDLE;
			end
			tlws_pkg::ST_FNV: begin
				if (sts.fnv_done) state_next = tlws_pkg::ST_EMIT;
			end
			tlws_pkg::ST_EMIT: begin
				if (out_take) begin
					if (sts.word_last) state_next = tlws_pkg::ST_IDLE;
					else state_next = tlws_pkg::ST_MIX;
				end
			end
			tlws_pkg::ST_MIX: state_next = tlws_pkg::ST_EMIT;
			default: state_next = tlws_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			tlws_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			tlws_pkg::ST_DECIDE: begin
				cmd.trip = sts.is_check && sts.trips;
				cmd.fnv_start = sts.is_check && sts.trips;
				cmd.out_single = !(sts.is_check && sts.trips);
			end
			tlws_pkg::ST_SINGLE: out_valid = 1'b1;
			tlws_pkg::ST_FNV: begin
				cmd.fnv_step = !sts.fnv_done;
				cmd.out_word = sts.fnv_done;
			end
			tlws_pkg::ST_EMIT: out_valid = 1'b1;
			tlws_pkg::ST_MIX: begin
				cmd.mix_step = 1'b1;
				cmd.out_word = 1'b1;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == tlws_pkg::ST_DECIDE)
		else $error("accepted item did not start evaluation");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input open while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlws_pkg::ST_MIX) |=> state_q == tlws_pkg::ST_EMIT)
		else $error("mix step not followed by emit");
endmodule
`default_nettype wire

### src/tlws_dp.sv
// Datapath: state registers, threshold compare, serial FNV and mixing unit.
`default_nettype none
module tlws_dp #(
	parameter int RECORD_BYTES = tlws_pkg::RecordBytesDefault,
	parameter int SIGNATURE_WORDS = tlws_pkg::SignatureWordsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire tlws_pkg::cmd_t cmd,
	output tlws_pkg::sts_t sts,
	input wire tlws_pkg::in_item_t in_item,
	input wire logic [63:0] drift_q,
	input wire logic [63:0] entropy_q,
	input wire logic [63:0] inflation_q,
	input wire logic [63:0] consensus_q,
	input wire logic [31:0] age_q,
	output tlws_pkg::out_item_t out_item
);
	localparam int ByteCntW = $clog2(RECORD_BYTES + 1);
	localparam int WordW = (SIGNATURE_WORDS > 1) ? $clog2(SIGNATURE_WORDS) : 1;
	localparam int HeadBits = 8 * tlws_pkg::HeadBytes;

	tlws_pkg::in_item_t item_q;
	logic [1:0] mode_q;
	logic lock_q;
	logic [63:0] next_incident_q;
	logic [63:0] id_q;
	logic [31:0] hash_q;
	logic [ByteCntW-1:0] byte_q;
	logic [WordW-1:0] word_q;
	logic [HeadBits-1:0] rec_q;
	logic contained_q;
	tlws_pkg::out_item_t out_q;

	logic [63:0] vbits, tbits;
	logic [31:0] fnv_x, fnv_p, mix_x, mix_p;
	logic [7:0] cur_byte;

	always_comb begin
		unique case (item_q.trigger_kind)
			tlws_pkg::KindDrift: tbits = drift_q;
			tlws_pkg::KindEntropy: tbits = entropy_q;
			tlws_pkg::KindInflation: tbits = inflation_q;
			tlws_pkg::KindConsensus: tbits = consensus_q;
			default: tbits = tlws_pkg::int_to_double(age_q);
		endcase
		vbits = (item_q.trigger_kind == tlws_pkg::KindAge) ?
			tlws_pkg::int_to_double(item_q.day_count) : item_q.measured_value;
	end

	assign sts.is_check = (item_q.func == tlws_pkg::FUNC_CHECK) &&
		(item_q.trigger_kind >= tlws_pkg::KindDrift) &&
		(item_q.trigger_kind <= tlws_pkg::KindAge);
	assign sts.trips = !tlws_pkg::double_le(vbits, tbits);
	assign sts.fnv_done = (byte_q == ByteCntW'(RECORD_BYTES));
	assign sts.word_last = (32'(word_q) == 32'(SIGNATURE_WORDS - 1));

	assign cur_byte = (byte_q < ByteCntW'(tlws_pkg::HeadBytes)) ? rec_q[7:0] : 8'd0;
	assign fnv_x = hash_q ^ {24'd0, cur_byte};
	assign fnv_p = fnv_x * tlws_pkg::FnvPrime;
	assign mix_x = hash_q ^ (hash_q >> 3) ^ (hash_q << 7);
	assign mix_p = mix_x * tlws_pkg::FnvPrime;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			lock_q <= 1'b0;
			next_incident_q <= 64'd0;
			hash_q <= 32'd0;
		end else begin
			if (cmd.load) begin
				unique case (tlws_pkg::func_t'(in_item.func))
					tlws_pkg::FUNC_SHADOW: if (!lock_q) mode_q <= 2'd1;
					tlws_pkg::FUNC_UNLOCK: begin
						lock_q <= 1'b0;
						mode_q <= 2'd1;
					end
					tlws_pkg::FUNC_INIT: begin
						lock_q <= 1'b0;
						mode_q <= (in_item.start_mode == 2'd3) ? 2'd2 : in_item.start_mode;
					end
					default: ;
				endcase
			end
			if (cmd.trip) begin
				next_incident_q <= next_incident_q + 64'd1;
				mode_q <= 2'd0;
				lock_q <= 1'b1;
			end
			if (cmd.fnv_start) hash_q <= tlws_pkg::FnvBasis;
			else if (cmd.fnv_step) hash_q <= fnv_p;
			else if (cmd.mix_step) hash_q <= mix_p;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.trip) begin
			id_q <= next_incident_q;
			rec_q <= {tbits, vbits, 29'd0, item_q.trigger_kind, item_q.timestamp,
				next_incident_q};
			byte_q <= '0;
			word_q <= '0;
		end
		if (cmd.fnv_step) begin
			rec_q <= rec_q >> 8;
			byte_q <= byte_q + ByteCntW'(1);
		end
		if (cmd.out_single) begin
			out_q <= {1'b0, mode_q, lock_q, 64'd0, 3'd0, 32'd0, 1'b1};
		end
		if (cmd.out_word) begin
			out_q <= {1'b1, mode_q, lock_q, id_q, 3'(word_q + WordW'(cmd.mix_step)),
				(cmd.mix_step ? mix_p : hash_q),
				((32'(word_q) + 32'(cmd.mix_step)) == 32'(SIGNATURE_WORDS - 1))};
			if (cmd.mix_step) word_q <= word_q + WordW'(1);
		end
	end

	assign contained_q = out_q.contained;
	assign out_item = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trip |=> lock_q && mode_q == 2'd0)
		else $error("trip did not lock");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fnv_step |-> !sts.fnv_done)
		else $error("FNV stepped past record");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_word |=> contained_q)
		else $error("signature word not marked contained");
endmodule
`default_nettype wire

### src/threshold_lockout_with_signature.sv
// Top level: threshold lockout controller with incident signature output.
// A check item compares its measurement (double, or exact int-to-double for the
// age kind) against the configured limit; anything not at or below it, NaN
// included, drops mode to 0, sets the lock and emits SIGNATURE_WORDS items of
// signature, otherwise one plain item results. Items are handled one at a time:
// a non-tripping item goes through the decide state, then waits on the output
// handshake; a trip runs the byte-serial FNV-1a chain over RECORD_BYTES bytes on
// its own 32-bit multiplier, then each later signature word takes one mix multiply
// and one delivery. Thresholds are written over the APB port at byte addresses
// 0, 8, 16, 24, 32 (64-bit data); write only while idle.
`default_nettype none
module threshold_lockout_with_signature #(
	parameter int RECORD_BYTES = tlws_pkg::RecordBytesDefault,
	parameter int SIGNATURE_WORDS = tlws_pkg::SignatureWordsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	tlws_stream_if.sink in_ch,
	tlws_stream_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tlws_pkg::AddrWidth-1:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	logic [63:0] drift_q, entropy_q, inflation_q, consensus_q;
	logic [31:0] age_q;
	tlws_pkg::cmd_t cmd;
	tlws_pkg::sts_t sts;
	tlws_pkg::out_item_t out_item;

	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_q <= tlws_pkg::DriftReset;
			entropy_q <= tlws_pkg::EntropyReset;
			inflation_q <= tlws_pkg::InflationReset;
			consensus_q <= tlws_pkg::ConsensusReset;
			age_q <= tlws_pkg::AgeReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				tlws_pkg::AddrDrift: drift_q <= pwdata;
				tlws_pkg::AddrEntropy: entropy_q <= pwdata;
				tlws_pkg::AddrInflation: inflation_q <= pwdata;
				tlws_pkg::AddrConsensus: consensus_q <= pwdata;
				tlws_pkg::AddrAge: age_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			tlws_pkg::AddrDrift: prdata = drift_q;
			tlws_pkg::AddrEntropy: prdata = entropy_q;
			tlws_pkg::AddrInflation: prdata = inflation_q;
			tlws_pkg::AddrConsensus: prdata = consensus_q;
			tlws_pkg::AddrAge: prdata = {32'd0, age_q};
			default: prdata = 64'd0;
		endcase
	end

	tlws_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	tlws_dp #(
		.RECORD_BYTES(RECORD_BYTES),
		.SIGNATURE_WORDS(SIGNATURE_WORDS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_item(in_ch.data),
		.drift_q(drift_q),
		.entropy_q(entropy_q),
		.inflation_q(inflation_q),
		.consensus_q(consensus_q),
		.age_q(age_q),
		.out_item(out_item)
	);

	assign out_ch.data = out_item;
endmodule
`default_nettype wire
